FILE: design/mff_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mff_pkg
// Shared types and constants for the mesh frame forward filter.
// ----------------------------------------------------------------------------
package mff_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int TBL_IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HDR_BYTES   = 8;
  localparam int HDR_IW      = $clog2(HDR_BYTES);

  // header byte positions
  localparam logic [HDR_IW-1:0] POS_TYPE  = HDR_IW'(0);
  localparam logic [HDR_IW-1:0] POS_FROM1 = HDR_IW'(1);
  localparam logic [HDR_IW-1:0] POS_FROM2 = HDR_IW'(2);
  localparam logic [HDR_IW-1:0] POS_TO1   = HDR_IW'(3);
  localparam logic [HDR_IW-1:0] POS_TO2   = HDR_IW'(4);
  localparam logic [HDR_IW-1:0] POS_HOPS  = HDR_IW'(5);
  localparam logic [HDR_IW-1:0] POS_LIMIT = HDR_IW'(6);
  localparam logic [HDR_IW-1:0] POS_LEN   = HDR_IW'(7);

  // configuration register indexes
  localparam logic [1:0] REG_OWN_ID   = 2'd0;
  localparam logic [1:0] REG_IS_CHILD = 2'd1;
  localparam logic [1:0] REG_PREAMBLE = 2'd2;

  localparam logic [7:0] PREAMBLE_RESET = 8'd170;

  typedef enum logic [2:0] {
    V_LOCAL   = 3'd0,
    V_FORWARD = 3'd1,
    V_DUP     = 3'd2,
    V_HOPLIM  = 3'd3,
    V_PARENT  = 3'd4
  } verdict_t;

  typedef struct packed {
    logic idx_clr;
    logic hdr_wr;
    logic body_load;
    logic body_dec;
    logic decide;
  } mff_cmd_t;

  typedef struct packed {
    logic pre_hit;
    logic hdr_last;
    logic len_zero;
    logic body_last;
    logic out_hold;
  } mff_stat_t;

endpackage
`default_nettype wire

FILE: design/mff_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mff_dp
// Datapath: config registers, header store, body counter, forward table,
// verdict logic and the result register.
// ----------------------------------------------------------------------------
module mff_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mff_pkg::mff_cmd_t cmd,
  output mff_pkg::mff_stat_t     stat,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              cfg_wr,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             verdict,
  output logic [7:0]             source_id,
  output logic [7:0]             dest_id,
  output logic [7:0]             msg_type,
  output logic [7:0]             hops_out,
  output logic [7:0]             body_len
);
  import mff_pkg::*;

  logic [7:0]              own_id;
  logic                    is_child;
  logic [7:0]              preamble_byte;
  logic [HDR_IW-1:0]       hdr_idx;
  logic [7:0]              hdr [HDR_BYTES];
  logic [7:0]              body_remaining;
  logic [23:0]             tbl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  tbl_valid;
  logic [TBL_IW-1:0]       tbl_ptr;

  logic [7:0]  src, dst, hops, limit;
  logic [23:0] triple;
  logic        dup;
  verdict_t    v_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id        <= '0;
      is_child      <= 1'b1;
      preamble_byte <= PREAMBLE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_OWN_ID:   own_id        <= cfg_data;
        REG_IS_CHILD: is_child      <= cfg_data[0];
        REG_PREAMBLE: preamble_byte <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx <= '0;
    end else if (cmd.idx_clr) begin
      hdr_idx <= '0;
    end else if (cmd.hdr_wr) begin
      hdr_idx <= hdr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_wr) begin
      hdr[hdr_idx] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_remaining <= '0;
    end else if (cmd.body_load) begin
      body_remaining <= rx_byte;
    end else if (cmd.body_dec) begin
      body_remaining <= body_remaining - 1'b1;
    end
  end

  assign src    = hdr[POS_FROM1] | hdr[POS_FROM2];
  assign dst    = hdr[POS_TO1] | hdr[POS_TO2];
  assign hops   = hdr[POS_HOPS];
  assign limit  = hdr[POS_LIMIT];
  assign triple = {src, dst, hdr[POS_TYPE]};

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[TBL_IW'(i)] && tbl[TBL_IW'(i)] == triple) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (!is_child) begin
      v_next = V_PARENT;
    end else if (dst == own_id) begin
      v_next = V_LOCAL;
    end else if (hops >= limit) begin
      v_next = V_HOPLIM;
    end else if (dup) begin
      v_next = V_DUP;
    end else begin
      v_next = V_FORWARD;
    end
  end

  // ring of recent forwards, valid bits mark filled slots
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      tbl_ptr   <= '0;
    end else if (cmd.decide && v_next == V_FORWARD) begin
      tbl_valid[tbl_ptr] <= 1'b1;
      tbl_ptr <= (tbl_ptr == TBL_IW'(TABLE_DEPTH - 1)) ? '0 : tbl_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && v_next == V_FORWARD) begin
      tbl[tbl_ptr] <= triple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      verdict   <= v_next;
      source_id <= src;
      dest_id   <= dst;
      msg_type  <= hdr[POS_TYPE];
      hops_out  <= (v_next == V_FORWARD) ? hops + 8'd1 : hops;
      body_len  <= hdr[POS_LEN];
    end
  end

  assign stat.pre_hit   = (rx_byte == preamble_byte);
  assign stat.hdr_last  = (hdr_idx == POS_LEN);
  assign stat.len_zero  = (rx_byte == 8'd0);
  assign stat.body_last = (body_remaining <= 8'd1);
  assign stat.out_hold  = out_valid && out_stall;

endmodule
`default_nettype wire

FILE: design/mff_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mff_ctrl
// Frame parser state machine: hunt, header, body and decision steps.
// ----------------------------------------------------------------------------
module mff_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mff_pkg::mff_stat_t stat,
  output mff_pkg::mff_cmd_t       cmd
);
  import mff_pkg::*;

  typedef enum logic [1:0] {
    S_HUNT,
    S_HEADER,
    S_BODY,
    S_DECIDE
  } state_t;

  state_t state;
  logic   acc;

  // the result register parts the sides; only the decision waits on it
  assign in_stall = (state == S_DECIDE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_HUNT: begin
        cmd.idx_clr = acc && stat.pre_hit;
      end
      S_HEADER: begin
        cmd.hdr_wr    = acc;
        cmd.body_load = acc && stat.hdr_last;
      end
      S_BODY: begin
        cmd.body_dec = acc;
      end
      S_DECIDE: begin
        cmd.decide = !stat.out_hold;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      unique case (state)
        S_HUNT: begin
          if (acc && stat.pre_hit) state <= S_HEADER;
        end
        S_HEADER: begin
          if (acc && stat.hdr_last) begin
            state <= stat.len_zero ? S_DECIDE : S_BODY;
          end
        end
        S_BODY: begin
          if (acc && stat.body_last) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!stat.out_hold) state <= S_HUNT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/mesh_frame_forward_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_frame_forward_filter
// Flood forwarder with duplicate suppression: parses radio frames byte by
// byte and gives one verdict per frame.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  rx_byte
//  out      out_valid/out_stall  verdict, source_id, dest_id, msg_type,
//                                hops_out, body_len
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one byte per cycle while not stalled; the byte that ends a frame leads
//  to a decision step in which the forward table is compared in parallel
//  and the result registered. bytes keep flowing while a result waits;
//  input stalls only in the decision step, which lasts as long as an
//  earlier result is held by out_stall. synchronous reset returns the
//  parser, table valid bits and config registers to their reset values.
// ----------------------------------------------------------------------------
module mesh_frame_forward_filter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      verdict,
  output logic [7:0]      source_id,
  output logic [7:0]      dest_id,
  output logic [7:0]      msg_type,
  output logic [7:0]      hops_out,
  output logic [7:0]      body_len,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import mff_pkg::*;

  mff_cmd_t  cmd;
  mff_stat_t stat;

  assign cfg_ready = 1'b1;

  mff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mff_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .rx_byte   (rx_byte),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict),
    .source_id (source_id),
    .dest_id   (dest_id),
    .msg_type  (msg_type),
    .hops_out  (hops_out),
    .body_len  (body_len)
  );

endmodule
`default_nettype wire
